[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath handoff types for the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_LEVELS      = 8;
  localparam int MIN_BLOCK_BYTES = 64;
  localparam int HEADER_BYTES    = 16;

  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int SLOT_W    = NUM_LEVELS - 1;
  localparam int NUM_SLOTS = 1 << SLOT_W;
  localparam int LINK_W    = SLOT_W + 1;
  localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);
  localparam int TOP_MAX   = NUM_LEVELS - 1;

  localparam int REQ_W     = 24;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int USED_W    = 14;
  localparam int TOP_W     = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LINK_W-1:0]    NO_SLOT      = LINK_W'(NUM_SLOTS);
  localparam logic [TOP_W-1:0]     TOP_RESET    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_IDX = 2'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_BIG     = 3'd2,
    ST_OOM     = 3'd3,
    ST_NULL    = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SEARCH,
    OP_LOAD_HEAD,
    OP_RD_S,
    OP_RD_B,
    OP_UNLINK_S,
    OP_UNLINK_B,
    OP_SPLIT_DN,
    OP_PUSH_S,
    OP_PUSH_B,
    OP_TAKE,
    OP_RD_INFO_S,
    OP_RD_INFO_B,
    OP_FREE_START,
    OP_MERGE
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e code;
    logic    result;
  } bba_cmd_t;

  typedef struct packed {
    logic init_pend;
    logic is_free;
    logic zero;
    logic big;
    logic null_addr;
    logic bad_addr;
    logic found;
    logic split_more;
    logic below_top;
    logic blk_ok;
    logic buddy_ok;
    logic out_busy;
  } bba_stat_t;

  function automatic logic [LVL_W-1:0] clamp_top(logic [TOP_W-1:0] v);
    logic [LVL_W-1:0] r;
    if (32'(v) > TOP_MAX) r = LVL_W'(TOP_MAX);
    else r = LVL_W'(v);
    return r;
  endfunction

endpackage

[rtl/bba_if.sv]
// ----------------------------------------------------------------------------
// bba request / response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [bba_pkg::REQ_W-1:0]  req_bytes;
  logic [bba_pkg::ADDR_W-1:0] free_addr;

  modport source (output valid, cmd, req_bytes, free_addr, input ready);
  modport sink   (input valid, cmd, req_bytes, free_addr, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::ADDR_W-1:0]   user_addr;
  logic [bba_pkg::LVL_W-1:0]    block_level;
  logic [bba_pkg::USED_W-1:0]   used_bytes;

  modport source (output valid, status, user_addr, block_level, used_bytes, input ready);
  modport sink   (input valid, status, user_addr, block_level, used_bytes, output ready);
endinterface

[rtl/bba_dp.sv]
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: free-list heads, link and slot-info memories, usage
// counter, configuration and the result register.
// ----------------------------------------------------------------------------
module bba_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bba_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         cmd_i,
  input  logic [bba_pkg::REQ_W-1:0]    req_bytes_i,
  input  logic [bba_pkg::ADDR_W-1:0]   free_addr_i,
  input  bba_pkg::bba_cmd_t            ctl_i,
  output bba_pkg::bba_stat_t           stat_o,
  bba_rsp_if.source                    rsp
);
  import bba_pkg::*;

  logic [TOP_W-1:0]  top_cfg_q;
  logic [ADDR_W-1:0] base_q;
  logic [LINK_W-1:0] head_q [NUM_LEVELS];
  logic [USED_W-1:0] used_q;
  logic              init_pend_q;
  logic [SLOT_W-1:0] init_idx_q;
  logic              out_valid_q;

  logic              cmd_q, zero_q, big_q, null_q, bad_q;
  logic [LVL_W-1:0]  tgt_q, cur_q, orig_q;
  logic [SLOT_W-1:0] s_q, b_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [LVL_W-1:0]  out_lvl_q;
  logic [USED_W-1:0] out_used_q;

  logic [LINK_W-1:0] nxt_mem [NUM_SLOTS];
  logic [LINK_W-1:0] prv_mem [NUM_SLOTS];
  logic [LVL_W-1:0]  lvl_mem [NUM_SLOTS];
  logic              fre_mem [NUM_SLOTS];
  logic              sta_mem [NUM_SLOTS];
  logic [LINK_W-1:0] nxt_rd_q, prv_rd_q;
  logic [LVL_W-1:0]  lvl_rd_q;
  logic              fre_rd_q, sta_rd_q;

  logic [LVL_W-1:0]  top;
  logic              reinit;
  logic [LVL_W-1:0]  new_top;
  logic [REQ_W:0]    need;
  logic [LVL_W-1:0]  fit;
  logic              fits;
  logic [ADDR_W-1:0] rel;
  logic [LVL_W-1:0]  srch;
  logic              found;
  logic [SLOT_W-1:0] x;
  logic [LINK_W-1:0] h;
  logic [SLOT_W-1:0] b_split, b_buddy, lo, hi;
  logic [SLOT_W-1:0] lnk_ra, info_ra;
  logic [LVL_W-1:0]  info_lvl;
  logic              info_fre, info_sta;
  logic              out_busy;

  logic              nxt_we, prv_we, lvl_we, fre_we, sta_we, head_we;
  logic [SLOT_W-1:0] nxt_wa, prv_wa, lvl_wa, fre_wa, sta_wa;
  logic [LINK_W-1:0] nxt_wd, prv_wd, head_wd;
  logic [LVL_W-1:0]  lvl_wd;
  logic              fre_wd, sta_wd;

  assign top     = clamp_top(top_cfg_q);
  assign reinit  = cfg_we_i && (cfg_idx_i == CFG_TOP_IDX);
  assign new_top = clamp_top(cfg_wdata_i[TOP_W-1:0]);
  assign out_busy = out_valid_q && !rsp.ready;

  // request decode
  always_comb begin
    need = {1'b0, req_bytes_i} + (REQ_W+1)'(HEADER_BYTES);
    fit  = '0;
    fits = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (LVL_W'(l) <= top && (ADDR_W'(MIN_BLOCK_BYTES) << l) >= ADDR_W'(need)) begin
        fit  = LVL_W'(l);
        fits = 1'b1;
      end
    end
    rel = free_addr_i - base_q - ADDR_W'(HEADER_BYTES);
  end

  // lowest non-empty list from the target level up to the top
  always_comb begin
    srch  = '0;
    found = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (LVL_W'(l) >= tgt_q && LVL_W'(l) <= top && !head_q[l][SLOT_W]) begin
        srch  = LVL_W'(l);
        found = 1'b1;
      end
    end
  end

  assign info_lvl = lvl_rd_q;
  assign info_fre = fre_rd_q;
  assign info_sta = sta_rd_q;

  assign x       = (ctl_i.op == OP_PUSH_B || ctl_i.op == OP_UNLINK_B) ? b_q : s_q;
  assign h       = head_q[cur_q];
  assign b_split = s_q + (SLOT_W'(1) << (cur_q - LVL_W'(1)));
  assign b_buddy = s_q ^ (SLOT_W'(1) << cur_q);
  assign lo      = (s_q < b_q) ? s_q : b_q;
  assign hi      = (s_q < b_q) ? b_q : s_q;
  assign lnk_ra  = (ctl_i.op == OP_RD_B) ? b_q : s_q;
  assign info_ra = (ctl_i.op == OP_RD_INFO_B) ? b_buddy : s_q;

  // memory write control
  always_comb begin
    nxt_we = 1'b0; nxt_wa = x; nxt_wd = h;
    prv_we = 1'b0; prv_wa = h[SLOT_W-1:0]; prv_wd = {1'b0, x};
    lvl_we = 1'b0; lvl_wa = x; lvl_wd = cur_q;
    fre_we = 1'b0; fre_wa = x; fre_wd = 1'b1;
    sta_we = 1'b0; sta_wa = b_split; sta_wd = 1'b1;
    head_we = 1'b0; head_wd = {1'b0, x};
    case (ctl_i.op)
      OP_PUSH_S, OP_PUSH_B: begin
        nxt_we  = 1'b1;
        prv_we  = !h[SLOT_W];
        head_we = 1'b1;
        lvl_we  = 1'b1;
        fre_we  = 1'b1;
      end
      OP_UNLINK_S, OP_UNLINK_B: begin
        // a head has no meaningful back link
        if (h == {1'b0, x}) begin
          head_we = 1'b1;
          head_wd = nxt_rd_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_q[SLOT_W-1:0];
          nxt_wd = nxt_rd_q;
        end
        prv_we = !nxt_rd_q[SLOT_W];
        prv_wa = nxt_rd_q[SLOT_W-1:0];
        prv_wd = prv_rd_q;
      end
      OP_SPLIT_DN: sta_we = 1'b1;
      OP_TAKE: begin
        fre_we = 1'b1;
        fre_wa = s_q;
        fre_wd = 1'b0;
      end
      OP_MERGE: begin
        sta_we = 1'b1; sta_wa = hi; sta_wd = 1'b0;
        fre_we = 1'b1; fre_wa = hi; fre_wd = 1'b0;
      end
      default: ;
    endcase
    // clearing pass: one slot per cycle, slot 0 becomes the free top block
    if (init_pend_q) begin
      nxt_we = 1'b1; nxt_wa = init_idx_q; nxt_wd = NO_SLOT;
      lvl_we = 1'b1; lvl_wa = init_idx_q;
      lvl_wd = (init_idx_q == '0) ? top : '0;
      fre_we = 1'b1; fre_wa = init_idx_q; fre_wd = (init_idx_q == '0);
      sta_we = 1'b1; sta_wa = init_idx_q; sta_wd = (init_idx_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (fre_we) fre_mem[fre_wa] <= fre_wd;
    if (sta_we) sta_mem[sta_wa] <= sta_wd;
    nxt_rd_q    <= nxt_mem[lnk_ra];
    prv_rd_q    <= prv_mem[lnk_ra];
    lvl_rd_q    <= lvl_mem[info_ra];
    fre_rd_q    <= fre_mem[info_ra];
    sta_rd_q    <= sta_mem[info_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_cfg_q   <= TOP_RESET;
      base_q      <= '0;
      used_q      <= '0;
      init_pend_q <= 1'b1;
      init_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= (LVL_W'(l) == clamp_top(TOP_RESET)) ? '0 : NO_SLOT;
      end
    end else begin
      if (init_pend_q) begin
        init_idx_q <= init_idx_q + SLOT_W'(1);
        if (&init_idx_q) init_pend_q <= 1'b0;
      end
      if (head_we) head_q[cur_q] <= head_wd;
      case (ctl_i.op)
        OP_TAKE:       used_q <= used_q + (USED_W'(MIN_BLOCK_BYTES) << cur_q);
        OP_FREE_START: used_q <= used_q - (USED_W'(MIN_BLOCK_BYTES) << info_lvl);
        default: ;
      endcase
      if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
      if (ctl_i.result) out_valid_q <= 1'b1;
      if (cfg_we_i && cfg_idx_i == CFG_BASE_IDX) base_q <= cfg_wdata_i;
      if (reinit) begin
        top_cfg_q   <= cfg_wdata_i[TOP_W-1:0];
        used_q      <= '0;
        init_pend_q <= 1'b1;
        init_idx_q  <= '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
          head_q[l] <= (LVL_W'(l) == new_top) ? '0 : NO_SLOT;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_ACCEPT: begin
        cmd_q  <= cmd_i;
        zero_q <= (req_bytes_i == '0);
        big_q  <= !fits;
        tgt_q  <= fit;
        null_q <= (free_addr_i == '0);
        bad_q  <= (rel >= (ADDR_W'(MIN_BLOCK_BYTES) << top)) ||
                  (rel[MIN_SHIFT-1:0] != '0);
        s_q    <= rel[MIN_SHIFT +: SLOT_W];
      end
      OP_SEARCH: begin
        cur_q <= srch;
        s_q   <= head_q[srch][SLOT_W-1:0];
      end
      OP_LOAD_HEAD: s_q <= h[SLOT_W-1:0];
      OP_SPLIT_DN: begin
        cur_q <= cur_q - LVL_W'(1);
        b_q   <= b_split;
      end
      OP_RD_INFO_B: b_q <= b_buddy;
      OP_FREE_START: begin
        cur_q  <= info_lvl;
        orig_q <= info_lvl;
      end
      OP_MERGE: begin
        s_q   <= lo;
        cur_q <= cur_q + LVL_W'(1);
      end
      default: ;
    endcase
    if (ctl_i.result) begin
      out_status_q <= ctl_i.code;
      out_addr_q   <= '0;
      out_lvl_q    <= '0;
      out_used_q   <= used_q;
      if (ctl_i.code == ST_OK) begin
        if (cmd_q == CMD_ALLOC) begin
          out_addr_q <= base_q + (ADDR_W'(s_q) << MIN_SHIFT) + ADDR_W'(HEADER_BYTES);
          out_lvl_q  <= cur_q;
        end else begin
          out_lvl_q  <= orig_q;
        end
      end
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.user_addr   = out_addr_q;
  assign rsp.block_level = out_lvl_q;
  assign rsp.used_bytes  = out_used_q;

  always_comb begin
    stat_o.init_pend  = init_pend_q;
    stat_o.is_free    = (cmd_q == CMD_FREE);
    stat_o.zero       = zero_q;
    stat_o.big        = big_q;
    stat_o.null_addr  = null_q;
    stat_o.bad_addr   = bad_q;
    stat_o.found      = found;
    stat_o.split_more = (cur_q > tgt_q);
    stat_o.below_top  = (cur_q < top);
    stat_o.blk_ok     = info_sta && !info_fre;
    stat_o.buddy_ok   = info_sta && info_fre && (info_lvl == cur_q);
    stat_o.out_busy   = out_busy;
  end

`ifndef ASSERT_OFF
  a_used_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op != OP_TAKE && ctl_i.op != OP_FREE_START && !reinit) |=> $stable(used_q))
    else $error("usage count moved without an allocate or free");
  a_split_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_SPLIT_DN) |-> (cur_q != '0))
    else $error("split below the smallest level");
  a_push_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_PUSH_S || ctl_i.op == OP_PUSH_B) |-> (h != {1'b0, x}))
    else $error("slot pushed onto a list it already heads");
  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.result |-> !out_busy)
    else $error("result overwrites a beat not yet taken");
`endif

endmodule

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate (search, split, take) and free (check, push, merge).
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bba_pkg::bba_stat_t stat_i,
  output bba_pkg::bba_cmd_t  ctl_o
);
  import bba_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECODE = 5'd1;
  localparam logic [4:0] S_A_LOOP = 5'd2;
  localparam logic [4:0] S_A_UNL  = 5'd3;
  localparam logic [4:0] S_A_DN   = 5'd4;
  localparam logic [4:0] S_A_PS   = 5'd5;
  localparam logic [4:0] S_A_PB   = 5'd6;
  localparam logic [4:0] S_A_FRD  = 5'd7;
  localparam logic [4:0] S_A_FUNL = 5'd8;
  localparam logic [4:0] S_A_TAKE = 5'd9;
  localparam logic [4:0] S_F_CHK  = 5'd10;
  localparam logic [4:0] S_F_PS   = 5'd11;
  localparam logic [4:0] S_F_LOOP = 5'd12;
  localparam logic [4:0] S_F_BCHK = 5'd13;
  localparam logic [4:0] S_F_UB   = 5'd14;
  localparam logic [4:0] S_F_RS   = 5'd15;
  localparam logic [4:0] S_F_US   = 5'd16;
  localparam logic [4:0] S_F_MRG  = 5'd17;
  localparam logic [4:0] S_RES    = 5'd18;

  logic [4:0] state_q, state_d;
  status_e    code_q, code_d;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.init_pend;

  always_comb begin
    state_d      = state_q;
    code_d       = code_q;
    ctl_o.op     = OP_NONE;
    ctl_o.code   = code_q;
    ctl_o.result = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ctl_o.op = OP_ACCEPT;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.is_free) begin
          if (stat_i.zero) begin
            code_d = ST_ZERO; state_d = S_RES;
          end else if (stat_i.big) begin
            code_d = ST_BIG; state_d = S_RES;
          end else begin
            ctl_o.op = OP_SEARCH;
            if (stat_i.found) state_d = S_A_LOOP;
            else begin
              code_d = ST_OOM; state_d = S_RES;
            end
          end
        end else if (stat_i.null_addr) begin
          code_d = ST_NULL; state_d = S_RES;
        end else if (stat_i.bad_addr) begin
          code_d = ST_INVALID; state_d = S_RES;
        end else begin
          ctl_o.op = OP_RD_INFO_S;
          state_d  = S_F_CHK;
        end
      end
      S_A_LOOP: begin
        if (stat_i.split_more) begin
          ctl_o.op = OP_RD_S;
          state_d  = S_A_UNL;
        end else begin
          ctl_o.op = OP_LOAD_HEAD;
          state_d  = S_A_FRD;
        end
      end
      S_A_UNL: begin ctl_o.op = OP_UNLINK_S; state_d = S_A_DN; end
      S_A_DN:  begin ctl_o.op = OP_SPLIT_DN; state_d = S_A_PS; end
      S_A_PS:  begin ctl_o.op = OP_PUSH_S;   state_d = S_A_PB; end
      S_A_PB:  begin ctl_o.op = OP_PUSH_B;   state_d = S_A_LOOP; end
      S_A_FRD: begin ctl_o.op = OP_RD_S;     state_d = S_A_FUNL; end
      S_A_FUNL: begin ctl_o.op = OP_UNLINK_S; state_d = S_A_TAKE; end
      S_A_TAKE: begin
        ctl_o.op = OP_TAKE;
        code_d   = ST_OK;
        state_d  = S_RES;
      end
      S_F_CHK: begin
        if (!stat_i.blk_ok) begin
          code_d = ST_INVALID; state_d = S_RES;
        end else begin
          ctl_o.op = OP_FREE_START;
          state_d  = S_F_PS;
        end
      end
      S_F_PS: begin ctl_o.op = OP_PUSH_S; state_d = S_F_LOOP; end
      S_F_LOOP: begin
        if (stat_i.below_top) begin
          ctl_o.op = OP_RD_INFO_B;
          state_d  = S_F_BCHK;
        end else begin
          code_d = ST_OK; state_d = S_RES;
        end
      end
      S_F_BCHK: begin
        if (stat_i.buddy_ok) begin
          ctl_o.op = OP_RD_B;
          state_d  = S_F_UB;
        end else begin
          code_d = ST_OK; state_d = S_RES;
        end
      end
      S_F_UB:  begin ctl_o.op = OP_UNLINK_B; state_d = S_F_RS; end
      S_F_RS:  begin ctl_o.op = OP_RD_S;     state_d = S_F_US; end
      S_F_US:  begin ctl_o.op = OP_UNLINK_S; state_d = S_F_MRG; end
      S_F_MRG: begin ctl_o.op = OP_MERGE;    state_d = S_F_PS; end
      S_RES: begin
        if (!stat_i.out_busy) begin
          ctl_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

[rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator with per-level LIFO free lists kept in slot memories.
//
//   channel  dir  handshake    beat contents
//   req      in   valid/ready  cmd, req_bytes, free_addr
//   rsp      out  valid/ready  status, user_addr, block_level, used_bytes
//   cfg      in   write only   cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// Allocate: search, split to the target level, take. Free: check, push, merge
// with free buddies up to the top; rejects go straight to the result. Link
// memory reads are registered. One request in flight at a time; a finished
// result waits in the output register while the next beat enters. After
// reset or a top-level write, a clearing pass over all 128 slots initializes
// the slot memories; requests wait for it.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata_i,
  bba_req_if.sink                       req,
  bba_rsp_if.source                     rsp
);
  import bba_pkg::*;

  bba_cmd_t  ctl;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (req.cmd),
    .req_bytes_i (req.req_bytes),
    .free_addr_i (req.free_addr),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .rsp         (rsp)
  );

endmodule
